@@ hdl/cdrom_controller_host_registers_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the CD drive host register block
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the asynchronous reset is active.
// ----------------------------------------------------------------------------
`ifndef CDROM_CONTROLLER_HOST_REGISTERS_ASSERT_SVH
`define CDROM_CONTROLLER_HOST_REGISTERS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDRC_ASSERT_SAME(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDRC_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/cdrc_pkg.sv @@
// ----------------------------------------------------------------------------
// CD drive host register package
// Access and result types, register numbers, command codes and reply ROMs.
// ----------------------------------------------------------------------------
`default_nettype none

package cdrc_pkg;

	localparam int PARAM_DEPTH = 8;
	localparam int REPLY_DEPTH = 8;
	localparam int PARAM_AW = $clog2(PARAM_DEPTH);
	localparam int REPLY_AW = $clog2(REPLY_DEPTH);

	localparam logic ACC_READ  = 1'b0;
	localparam logic ACC_WRITE = 1'b1;

	localparam logic [1:0] REG_STATUS = 2'd0;
	localparam logic [1:0] REG_CMD    = 2'd1;
	localparam logic [1:0] REG_PARAM  = 2'd2;
	localparam logic [1:0] REG_UNLOCK = 2'd3;

	localparam logic [7:0] CMD_INIT = 8'h0a;
	localparam logic [7:0] CMD_TEST = 8'h19;

	localparam logic [7:0] SUB_ROM4  = 8'h20;
	localparam logic [7:0] SUB_ROM8A = 8'h22;
	localparam logic [7:0] SUB_ROM8B = 8'h23;

	localparam logic [7:0] STATUS_BASE  = 8'h0f;
	localparam logic [7:0] STATUS_READY = 8'h20;
	localparam logic [7:0] STAT_INIT    = 8'h02;
	localparam logic [7:0] STAT_TEST    = 8'h03;

	localparam logic [7:0] UNLOCK_FIRST = 8'h01;
	localparam logic [7:0] UNLOCK_NEXT  = 8'h07;

	localparam logic [1:0] UNLOCK_IDLE  = 2'd0;
	localparam logic [1:0] UNLOCK_ONE   = 2'd1;
	localparam logic [1:0] UNLOCK_TWO   = 2'd2;

	localparam logic [3:0] COUNT_INIT = 4'd1;
	localparam logic [3:0] COUNT_ROM4 = 4'd4;
	localparam logic [3:0] COUNT_ROM8 = 4'd8;

	localparam logic [7:0] ROM_SUB20 [4] = '{8'h98, 8'h06, 8'h10, 8'hC3};
	localparam logic [7:0] ROM_SUB22 [8] = '{8'h66, 8'h6F, 8'h72, 8'h20,
		8'h45, 8'h75, 8'h72, 8'h6F};
	localparam logic [7:0] ROM_SUB23 [8] = '{8'h43, 8'h58, 8'h44, 8'h32,
		8'h39, 8'h34, 8'h30, 8'h51};

	typedef struct packed {
		logic [7:0] write_byte;
		logic [1:0] reg_select;
		logic       cmd;
	} access_t;

	typedef struct packed {
		logic       irq_pulse;
		logic [7:0] read_byte;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/cdrc_core.sv @@
// ----------------------------------------------------------------------------
// CD drive host register core
// Holds the parameter and reply buffers, pointers, flags and status, and
// computes the result of one host access against them in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  cdrc_pkg::access_t req,
	output cdrc_pkg::result_t res
);
	import cdrc_pkg::*;

	logic [7:0]          param_q [PARAM_DEPTH];
	logic [7:0]          param_d [PARAM_DEPTH];
	logic [7:0]          reply_q [REPLY_DEPTH];
	logic [7:0]          reply_d [REPLY_DEPTH];
	logic [PARAM_AW-1:0] param_pos_q, param_pos_d;
	logic [3:0]          reply_pos_q, reply_pos_d;
	logic [3:0]          reply_count_q, reply_count_d;
	logic                reply_ready_q, reply_ready_d;
	logic [1:0]          unlock_q, unlock_d;
	logic [7:0]          status_q, status_d;
	logic                have_reply;
	logic [3:0]          pos_inc;

	assign have_reply = reply_ready_q && (reply_count_q != 4'd0);
	assign pos_inc    = reply_pos_q + 4'd1;

	always_comb begin
		param_d       = param_q;
		reply_d       = reply_q;
		param_pos_d   = param_pos_q;
		reply_pos_d   = reply_pos_q;
		reply_count_d = reply_count_q;
		reply_ready_d = reply_ready_q;
		unlock_d      = unlock_q;
		status_d      = status_q;
		res.read_byte = 8'h00;
		res.irq_pulse = 1'b0;
		if (req.cmd == ACC_READ) begin
			case (req.reg_select)
				REG_STATUS: begin
					res.read_byte = have_reply ? (STATUS_BASE | STATUS_READY) : STATUS_BASE;
				end
				REG_CMD: begin
					if (have_reply) begin
						res.read_byte = reply_q[reply_pos_q[REPLY_AW-1:0]];
					end
					if (reply_ready_q) begin
						reply_pos_d = pos_inc;
						if (pos_inc == reply_count_q) begin
							reply_ready_d = 1'b0;
						end
					end
				end
				REG_PARAM: begin
					res.read_byte = 8'h00;
				end
				default: begin
					res.read_byte = status_q;
				end
			endcase
		end else begin
			case (req.reg_select)
				REG_STATUS: begin
					param_pos_d = '0;
					if (req.write_byte == 8'h00) begin
						reply_ready_d = 1'b0;
					end else begin
						if (req.write_byte[0]) begin
							reply_ready_d = 1'b1;
						end
						if (req.write_byte == UNLOCK_FIRST) begin
							unlock_d = UNLOCK_ONE;
						end
					end
				end
				REG_CMD: begin
					res.irq_pulse = 1'b1;
					if (req.write_byte == CMD_INIT) begin
						reply_pos_d   = 4'd0;
						reply_count_d = COUNT_INIT;
						status_d      = STAT_INIT;
						reply_d[0]    = STAT_INIT;
					end else if (req.write_byte == CMD_TEST) begin
						status_d = STAT_TEST;
						case (param_q[0])
							SUB_ROM4: begin
								for (int i = 0; i < 4; i++) begin
									reply_d[i] = ROM_SUB20[i];
								end
								reply_pos_d   = 4'd0;
								reply_count_d = COUNT_ROM4;
							end
							SUB_ROM8A: begin
								for (int i = 0; i < REPLY_DEPTH; i++) begin
									reply_d[i] = ROM_SUB22[i];
								end
								reply_pos_d   = 4'd0;
								reply_count_d = COUNT_ROM8;
							end
							SUB_ROM8B: begin
								for (int i = 0; i < REPLY_DEPTH; i++) begin
									reply_d[i] = ROM_SUB23[i];
								end
								reply_pos_d   = 4'd0;
								reply_count_d = COUNT_ROM8;
							end
							default: begin
							end
						endcase
					end
				end
				REG_PARAM: begin
					if (unlock_q == UNLOCK_TWO && req.write_byte == UNLOCK_NEXT) begin
						param_pos_d   = '0;
						reply_ready_d = 1'b1;
						unlock_d      = UNLOCK_IDLE;
						status_d      = 8'h00;
					end else begin
						unlock_d             = UNLOCK_IDLE;
						param_d[param_pos_q] = req.write_byte;
						if (param_pos_q != PARAM_AW'(PARAM_DEPTH - 1)) begin
							param_pos_d = param_pos_q + PARAM_AW'(1);
						end
					end
				end
				default: begin
					if (req.write_byte == UNLOCK_NEXT && unlock_q == UNLOCK_ONE) begin
						unlock_d = UNLOCK_TWO;
					end else begin
						unlock_d = UNLOCK_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PARAM_DEPTH; i++) begin
				param_q[i] <= 8'h00;
			end
			for (int i = 0; i < REPLY_DEPTH; i++) begin
				reply_q[i] <= 8'h00;
			end
			param_pos_q   <= '0;
			reply_pos_q   <= 4'd0;
			reply_count_q <= 4'd0;
			reply_ready_q <= 1'b0;
			unlock_q      <= UNLOCK_IDLE;
			status_q      <= 8'h00;
		end else if (go) begin
			param_q       <= param_d;
			reply_q       <= reply_d;
			param_pos_q   <= param_pos_d;
			reply_pos_q   <= reply_pos_d;
			reply_count_q <= reply_count_d;
			reply_ready_q <= reply_ready_d;
			unlock_q      <= unlock_d;
			status_q      <= status_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/cdrom_controller_host_registers.sv @@
// ----------------------------------------------------------------------------
// CD drive controller host registers
// Datapath: the input transfer is registered in the access stage; when the output
// is free, the core result is registered in the result stage and shown on the
// master side. One register stage holds the access and one holds the result.
// Throughput: one access per cycle while the master side takes each result; the result register frees as it is taken.
// Reset: arst_n clears all buffers, pointers, flags, status and valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cdrom_controller_host_registers_assert.svh"

module cdrom_controller_host_registers (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // cmd, reg_select[1:0], write_byte[7:0], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_byte[7:0], irq_pulse, zero fill
);
	import cdrc_pkg::*;

	logic    valid_s1;
	access_t req_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_c;
	logic    advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= access_t'(s_tdata[10:0]);
		end
	end

	cdrc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.req    (req_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2};

	`CDRC_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !valid_s1, s_tready, "input stage empty but not ready")
	`CDRC_ASSERT_NEXT(a_stalled_item_kept, clk, arst_n, valid_s1 && !s_tready, valid_s1, "stalled access lost")
	`CDRC_ASSERT_NEXT(a_result_loaded, clk, arst_n, advance, valid_s2, "processed access gave no result")
	`CDRC_ASSERT_NEXT(a_result_held, clk, arst_n, valid_s2 && !m_tready, valid_s2 && $stable(res_s2), "waiting result changed")

endmodule

`default_nettype wire
